@@ rtl/core/csdps_pkg.sv @@
// ----------------------------------------------------------------------------
// csdps_pkg
// Shared types and constants of the pair scoring core.
// ----------------------------------------------------------------------------
`default_nettype none

package csdps_pkg;

  localparam int unsigned ScoreW     = 16;
  localparam int unsigned IndexW     = 12;
  localparam int unsigned NumW       = 17;  // exact Q.15 magnitudes
  localparam int unsigned RootW      = 16;  // floor(sqrt(s << 15)) < 2^16
  localparam int unsigned RadW       = 32;  // radicand s << 15
  localparam int unsigned DivW       = NumW + 8;  // numerator << 8
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ScoreW-1:0] ScoreMax = '1;

  localparam logic [CfgIdxW-1:0] CFG_C_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_S_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_D_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    CLASS_NONE      = 2'd0,
    CLASS_CONSERVED = 2'd1,
    CLASS_SPECIFIC  = 2'd2,
    CLASS_DIFFER    = 2'd3
  } pair_class_e;

  typedef struct packed {
    logic signed [15:0] avg_corr_a;
    logic signed [15:0] avg_corr_b;
    logic signed [15:0] var_a;
    logic signed [15:0] var_b;
    logic [IndexW-1:0]  pair_first;
    logic [IndexW-1:0]  pair_second;
  } in_item_t;

  typedef struct packed {
    logic [ScoreW-1:0] c_score;
    logic [ScoreW-1:0] s_score;
    logic [ScoreW-1:0] d_score;
    pair_class_e       pair_class;
    logic              zero_spread;
    logic [IndexW-1:0] out_first;
    logic [IndexW-1:0] out_second;
  } out_item_t;

  // Pair with its spread and score numerators, handed from front to back.
  typedef struct packed {
    logic [NumW-1:0]   spread;
    logic [NumW-1:0]   c_num;
    logic [NumW-1:0]   s_num;
    logic [NumW-1:0]   d_num;
    logic [IndexW-1:0] first;
    logic [IndexW-1:0] second;
  } work_t;

  typedef struct packed {
    logic [ScoreW-1:0] c_thr;
    logic [ScoreW-1:0] s_thr;
    logic [ScoreW-1:0] d_thr;
  } thresholds_t;

endpackage

`default_nettype wire

@@ rtl/core/csdps_front.sv @@
// ----------------------------------------------------------------------------
// csdps_front
// Accepts pairs, forms the spread magnitude and the three score numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module csdps_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire csdps_pkg::in_item_t in_item_i,
  output logic                   push_o,
  output csdps_pkg::work_t       push_data_o,
  input  wire logic              full_i
);

  logic               valid_q, valid_d;
  csdps_pkg::work_t   work_q, work_d;
  logic signed [16:0] sum_ab, sum_v;
  logic [15:0]        mag_a, mag_b;
  logic [16:0]        c_mag;

  assign push_o      = valid_q && !full_i;
  assign in_ready_o  = !valid_q || !full_i;
  assign push_data_o = work_q;

  always_comb begin
    sum_ab = {in_item_i.avg_corr_a[15], in_item_i.avg_corr_a}
           + {in_item_i.avg_corr_b[15], in_item_i.avg_corr_b};
    sum_v  = {in_item_i.var_a[15], in_item_i.var_a}
           + {in_item_i.var_b[15], in_item_i.var_b};
    mag_a  = in_item_i.avg_corr_a[15] ? 16'(-in_item_i.avg_corr_a)
                                      : 16'(in_item_i.avg_corr_a);
    mag_b  = in_item_i.avg_corr_b[15] ? 16'(-in_item_i.avg_corr_b)
                                      : 16'(in_item_i.avg_corr_b);
    c_mag  = sum_ab[16] ? 17'(-sum_ab) : 17'(sum_ab);
    work_d.spread = sum_v[16] ? 17'(-sum_v) : 17'(sum_v);
    work_d.c_num  = c_mag;
    work_d.s_num  = (mag_a > mag_b) ? 17'(mag_a - mag_b) : 17'(mag_b - mag_a);
    work_d.d_num  = 17'(mag_a) + 17'(mag_b) - c_mag;
    work_d.first  = in_item_i.pair_first;
    work_d.second = in_item_i.pair_second;
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= work_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/csdps_queue.sv @@
// ----------------------------------------------------------------------------
// csdps_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module csdps_queue #(
  parameter int unsigned Depth = csdps_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire csdps_pkg::work_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output csdps_pkg::work_t      pop_data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  csdps_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/csdps_back.sv @@
// ----------------------------------------------------------------------------
// csdps_back
// Pipelined square root (two radicand bits a stage), three pipelined
// restoring dividers (one quotient bit a stage), then saturate and class.
// ----------------------------------------------------------------------------
`default_nettype none

module csdps_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  output logic                     pop_o,
  input  wire csdps_pkg::work_t    work_i,
  input  wire csdps_pkg::thresholds_t thr_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output csdps_pkg::out_item_t     out_item_o
);

  localparam int unsigned SqSt  = csdps_pkg::RootW;
  localparam int unsigned DvSt  = csdps_pkg::DivW;
  localparam int unsigned NumW  = csdps_pkg::NumW;
  localparam int unsigned RootW = csdps_pkg::RootW;
  localparam int unsigned DivW  = csdps_pkg::DivW;

  typedef struct packed {
    logic [RootW:0]   rem;
    logic [RootW-1:0] root;
    csdps_pkg::work_t work;
  } sq_stage_t;

  typedef struct packed {
    logic [RootW-1:0]   v;
    logic [RootW-1:0]   rem_c, rem_s, rem_d;
    logic [DivW-1:0]    q_c, q_s, q_d;
    logic [NumW-1:0]    c_num, s_num, d_num;
    logic [csdps_pkg::IndexW-1:0] first, second;
  } dv_stage_t;

  sq_stage_t sq_q [SqSt];
  sq_stage_t sq_d [SqSt];
  dv_stage_t dv_q [DvSt];
  dv_stage_t dv_d [DvSt];
  logic [SqSt-1:0] sq_vld_q;
  logic [DvSt-1:0] dv_vld_q;
  logic            advance;
  logic            out_valid_q, out_valid_d;
  csdps_pkg::out_item_t out_q, out_d;

  // The whole pipe moves together; hold it while the result waits.
  assign advance     = !out_valid_q || out_ready_i;
  assign pop_o       = advance && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  function automatic logic [RootW-1:0] div_rem(input logic [RootW-1:0] rem,
                                               input logic bit_in,
                                               input logic [RootW-1:0] v);
    logic [RootW:0] t;
    t = {rem, bit_in};
    div_rem = (t >= {1'b0, v}) ? RootW'(t - {1'b0, v}) : RootW'(t);
  endfunction

  function automatic logic div_bit(input logic [RootW-1:0] rem,
                                   input logic bit_in,
                                   input logic [RootW-1:0] v);
    div_bit = ({rem, bit_in} >= {1'b0, v});
  endfunction

  function automatic logic [csdps_pkg::ScoreW-1:0] sat(input logic [DivW-1:0] q);
    sat = (q > DivW'(csdps_pkg::ScoreMax)) ? csdps_pkg::ScoreMax
                                           : csdps_pkg::ScoreW'(q);
  endfunction

  for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
    sq_stage_t        src;
    logic [RootW+2:0] tmp;
    logic [RootW+1:0] trial;
    logic [csdps_pkg::RadW-1:0] rad;

    always_comb begin
      if (k == 0) begin
        src = '0;
        src.work = work_i;
      end else begin
        src = sq_q[k-1];
      end
      rad   = {src.work.spread, 15'd0};
      tmp   = {src.rem, rad[csdps_pkg::RadW-1-2*k -: 2]};
      trial = {src.root, 2'b01};
      sq_d[k] = src;
      if (tmp >= {1'b0, trial}) begin
        sq_d[k].rem  = (RootW+1)'(tmp - {1'b0, trial});
        sq_d[k].root = {src.root[RootW-2:0], 1'b1};
      end else begin
        sq_d[k].rem  = (RootW+1)'(tmp);
        sq_d[k].root = {src.root[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        sq_q[k] <= sq_d[k];
      end
    end
  end

  for (genvar j = 0; j < DvSt; j++) begin : g_div
    dv_stage_t         src;
    logic [DivW-1:0]   dc, ds, dd;

    always_comb begin
      if (j == 0) begin
        src        = '0;
        src.v      = sq_q[SqSt-1].root;
        src.c_num  = sq_q[SqSt-1].work.c_num;
        src.s_num  = sq_q[SqSt-1].work.s_num;
        src.d_num  = sq_q[SqSt-1].work.d_num;
        src.first  = sq_q[SqSt-1].work.first;
        src.second = sq_q[SqSt-1].work.second;
      end else begin
        src = dv_q[j-1];
      end
      dc = {src.c_num, 8'd0};
      ds = {src.s_num, 8'd0};
      dd = {src.d_num, 8'd0};
      dv_d[j]       = src;
      dv_d[j].rem_c = div_rem(src.rem_c, dc[DivW-1-j], src.v);
      dv_d[j].rem_s = div_rem(src.rem_s, ds[DivW-1-j], src.v);
      dv_d[j].rem_d = div_rem(src.rem_d, dd[DivW-1-j], src.v);
      dv_d[j].q_c   = {src.q_c[DivW-2:0], div_bit(src.rem_c, dc[DivW-1-j], src.v)};
      dv_d[j].q_s   = {src.q_s[DivW-2:0], div_bit(src.rem_s, ds[DivW-1-j], src.v)};
      dv_d[j].q_d   = {src.q_d[DivW-2:0], div_bit(src.rem_d, dd[DivW-1-j], src.v)};
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  // A zero spread yields an all-ones quotient, which saturates by itself.
  always_comb begin
    out_d.c_score     = sat(dv_q[DvSt-1].q_c);
    out_d.s_score     = sat(dv_q[DvSt-1].q_s);
    out_d.d_score     = sat(dv_q[DvSt-1].q_d);
    out_d.zero_spread = (dv_q[DvSt-1].v == '0);
    out_d.out_first   = dv_q[DvSt-1].first;
    out_d.out_second  = dv_q[DvSt-1].second;
    if (out_d.c_score > thr_i.c_thr) begin
      out_d.pair_class = csdps_pkg::CLASS_CONSERVED;
    end else if (out_d.s_score > thr_i.s_thr) begin
      out_d.pair_class = csdps_pkg::CLASS_SPECIFIC;
    end else if (out_d.d_score > thr_i.d_thr) begin
      out_d.pair_class = csdps_pkg::CLASS_DIFFER;
    end else begin
      out_d.pair_class = csdps_pkg::CLASS_NONE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = dv_vld_q[DvSt-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q    <= '0;
      dv_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        sq_vld_q <= {sq_vld_q[SqSt-2:0], !empty_i};
        dv_vld_q <= {dv_vld_q[DvSt-2:0], sq_vld_q[SqSt-1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/csd_pair_scores_core.sv @@
// ----------------------------------------------------------------------------
// csd_pair_scores_core
// Conserved, specific and differentiated scores of one gene pair.
// ----------------------------------------------------------------------------
// Takes one pair per cycle and returns one scored pair per cycle, in order,
// while the output is not held. A pair passes through the front register,
// the queue, the pipelined square root (16 stages), the three pipelined
// dividers (25 stages) and the output register, where the result waits
// until taken while the whole pipe is held. A two-entry
// queue sits between the front and the pipe. Write the thresholds only while
// no pair is in flight.
`default_nettype none

module csd_pair_scores_core #(
  parameter int unsigned QueueDepth = csdps_pkg::QueueDepth
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire csdps_pkg::in_item_t       in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output csdps_pkg::out_item_t           out_item_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [csdps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [csdps_pkg::ScoreW-1:0]  cfg_data_i
);

  logic                   push, full, pop, empty;
  csdps_pkg::work_t       push_data, pop_data;
  csdps_pkg::thresholds_t thr_q, thr_d;

  always_comb begin
    thr_d = thr_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        csdps_pkg::CFG_C_THRESHOLD: thr_d.c_thr = cfg_data_i;
        csdps_pkg::CFG_S_THRESHOLD: thr_d.s_thr = cfg_data_i;
        csdps_pkg::CFG_D_THRESHOLD: thr_d.d_thr = cfg_data_i;
        default: thr_d = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= {3{csdps_pkg::ScoreMax}};
    end else begin
      thr_q <= thr_d;
    end
  end

  csdps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  csdps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  csdps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .work_i      (pop_data),
    .thr_i       (thr_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
